[rtl/core/serial_packet_deframer_top_macros.svh]
// ----------------------------------------------------------------------------
// serial_packet_deframer_top_macros
// Assertion macros shared by the deframer modules. Both expect signals named
// clock and reset in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SERIAL_PACKET_DEFRAMER_TOP_MACROS_SVH
`define SERIAL_PACKET_DEFRAMER_TOP_MACROS_SVH
`ifndef SYNTH
`define SPD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SPD_ASSERT_NEVER(lbl, expr, msg) \
   `SPD_ASSERT(lbl, !(expr), msg)
`else
`define SPD_ASSERT(lbl, prop, msg)
`define SPD_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[rtl/core/spd_pkg.sv]
// ----------------------------------------------------------------------------
// spd_pkg
// Types and constants shared by the serial packet deframer modules.
// ----------------------------------------------------------------------------
package spd_pkg;

   localparam int DEFAULT_BUFFER_DEPTH = 32;

   // Framing characters.
   localparam logic [7:0] HDR_BIN = 8'hFF;
   localparam logic [7:0] TRL_BIN = 8'hFE;
   localparam logic [7:0] HDR_TXT = 8'h40;
   localparam logic [7:0] CHR_CR  = 8'h0D;
   localparam logic [7:0] CHR_LF  = 8'h0A;
   localparam logic [7:0] CHR_NUL = 8'h00;

   localparam logic [5:0] PAYLOAD_LENGTH_RESET = 6'd4;

   // Register index, taken from address bit 2.
   localparam logic REG_FRAME_MODE     = 1'b0;
   localparam logic REG_PAYLOAD_LENGTH = 1'b1;

   localparam logic MODE_BINARY = 1'b0;
   localparam logic MODE_TEXT   = 1'b1;

   typedef enum logic [1:0] {
      OP_RX_BYTE    = 2'd0,
      OP_READ_CLEAR = 2'd1,
      OP_READ_ENTRY = 2'd2
   } spd_op_type;

   // Status reported for one item, after its update; a flag clear reports ready_flag as it was before the clear.
   typedef struct packed {
      logic       ready_flag;
      logic       frame_done;
      logic [5:0] payload_count;
      logic       overflow;
   } spd_status_type;

   // Buffer write request from the frame control.
   typedef struct packed {
      logic       wr_en;
      logic [7:0] wr_data;
   } spd_wreq_type;

endpackage

[rtl/core/spd_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// spd_frame_ctrl
// Frame parser: phase, fill count, ready and overflow flags, and the write
// request into the payload buffer for each received byte.
// ----------------------------------------------------------------------------
module spd_frame_ctrl import spd_pkg::*; #(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
   localparam int CW = $clog2(BUFFER_DEPTH + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  spd_op_type     opcode,
   input  logic [7:0]     rx_byte,
   input  logic           frame_mode,
   input  logic [5:0]     payload_length,
   output spd_status_type status,
   output spd_wreq_type   wreq,
   output logic [AW-1:0]  wr_addr
);

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_BODY = 2'd1,
      PH_TAIL = 2'd2
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            ready_ff, ready_in;
   logic            ovf_ff, ovf_in;
   logic            done;
   logic [CW-1:0]   len_eff;
   logic            cnt_room;

   // Binary length clamped to 1..BUFFER_DEPTH.
   always_comb begin
      if (payload_length == 6'd0) begin
         len_eff = CW'(1);
      end else if (32'(payload_length) > 32'(BUFFER_DEPTH)) begin
         len_eff = CW'(BUFFER_DEPTH);
      end else begin
         len_eff = CW'(payload_length);
      end
   end

   assign cnt_room = 32'(cnt_ff) < 32'(BUFFER_DEPTH);
   assign wr_addr  = AW'(cnt_ff);

   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      ready_in     = ready_ff;
      ovf_in       = ovf_ff;
      done         = 1'b0;
      wreq.wr_en   = 1'b0;
      wreq.wr_data = rx_byte;
      if (accept && opcode == OP_RX_BYTE) begin
         case (phase_ff)
            PH_BODY: begin
               if (frame_mode == MODE_BINARY) begin
                  wreq.wr_en = cnt_room;
                  if (cnt_room) begin
                     cnt_in = cnt_ff + CW'(1);
                  end
                  if (cnt_in >= len_eff) begin
                     phase_in = PH_TAIL;
                  end
               end else begin
                  if (rx_byte == CHR_CR) begin
                     phase_in = PH_TAIL;
                  end else if (32'(cnt_ff) + 32'd1 < 32'(BUFFER_DEPTH)) begin
                     wreq.wr_en = 1'b1;
                     cnt_in     = cnt_ff + CW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
            PH_TAIL: begin
               if (frame_mode == MODE_BINARY) begin
                  if (rx_byte == TRL_BIN) begin
                     phase_in = PH_WAIT;
                     ready_in = 1'b1;
                     done     = 1'b1;
                  end
               end else if (rx_byte == CHR_LF) begin
                  phase_in     = PH_WAIT;
                  wreq.wr_en   = cnt_room;
                  wreq.wr_data = CHR_NUL;
                  ready_in     = 1'b1;
                  done         = 1'b1;
               end
            end
            default: begin
               phase_in = PH_WAIT;
               if ((frame_mode == MODE_BINARY && rx_byte == HDR_BIN) ||
                   (frame_mode == MODE_TEXT && rx_byte == HDR_TXT && !ready_ff)) begin
                  phase_in = PH_BODY;
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
               end
            end
         endcase
      end else if (accept && opcode == OP_READ_CLEAR) begin
         ready_in = 1'b0;
      end
   end

   always_comb begin
      status.ready_flag    = (opcode == OP_READ_CLEAR) ? ready_ff : ready_in;
      status.frame_done    = done;
      status.payload_count = 6'(cnt_in);
      status.overflow      = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         cnt_ff   <= '0;
         ready_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         ready_ff <= ready_in;
         ovf_ff   <= ovf_in;
      end
   end

`include "serial_packet_deframer_top_macros.svh"

   `SPD_ASSERT_NEVER(a_cnt_bound, 32'(cnt_ff) > 32'(BUFFER_DEPTH), "fill count beyond buffer")
   `SPD_ASSERT(a_done_sets_ready, accept && done |=> ready_ff, "frame end did not set ready")
   `SPD_ASSERT(a_text_last_nul, wreq.wr_en && frame_mode == MODE_TEXT && (32'(wr_addr) == 32'(BUFFER_DEPTH) - 32'd1) |-> wreq.wr_data == CHR_NUL, "text frame overwrote terminator slot")
   `SPD_ASSERT(a_bin_fill_step, accept && opcode == OP_RX_BYTE && phase_ff == PH_BODY && frame_mode == MODE_BINARY && cnt_room |=> 32'(cnt_ff) == 32'($past(cnt_ff)) + 32'd1, "binary body byte not counted")

endmodule

[rtl/core/serial_packet_deframer_top.sv]
// ----------------------------------------------------------------------------
// serial_packet_deframer_top
// Serial packet deframer: binary and text framing into a payload buffer.
// ----------------------------------------------------------------------------
// The deframer takes one item per clock cycle while req_tready is high and
// returns exactly one result item per input item, in the cycle after it is
// accepted. Each item is a received byte, a read-and-clear of the frame-ready
// flag, or a read of one buffer entry. This timing is set by the payload
// buffer, a single memory with one write port and one registered read port: a
// byte is written at the edge that accepts it, and a buffer read returns its
// data in the result register in the cycle after. The result register decouples the two
// sides, so req_tready only falls while a result is held and rsp_tready is
// low. The buffer has no reset and needs no clearing pass after reset;
// reading an entry never written since reset returns an undefined value.
// Configuration (frame mode at byte address 0, binary payload length at
// byte address 4) is written through the csr_ port while the block is idle.
// ----------------------------------------------------------------------------
module serial_packet_deframer_top import spd_pkg::*; #(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [12:8] read_index, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] ready_flag, [8:1] read_data,
                                    // [14:9] payload_count, [15] overflow
   output logic        rsp_tlast,   // frame_done
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   // Configuration registers.
   logic       mode_ff, mode_in;
   logic [5:0] len_ff, len_in;
   logic       csr_wr;

   // Input item fields.
   spd_op_type opcode;
   logic [7:0] rx_byte;
   logic [4:0] read_index;
   logic       accept;
   logic       rd_hit;

   // Frame control.
   spd_status_type status;
   spd_wreq_type   wreq;
   logic [AW-1:0]  wr_addr;

   // Payload buffer with its registered read port.
   logic [7:0] store_mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   // Result register.
   logic           rsp_valid_ff, rsp_valid_in;
   spd_status_type rsp_status_ff;
   logic           rd_sel_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_FRAME_MODE:     mode_in = csr_pwdata[0];
            REG_PAYLOAD_LENGTH: len_in  = csr_pwdata[5:0];
            default:            mode_in = mode_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_FRAME_MODE:     csr_prdata = {31'd0, mode_ff};
         REG_PAYLOAD_LENGTH: csr_prdata = {26'd0, len_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BINARY;
         len_ff  <= PAYLOAD_LENGTH_RESET;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
      end
   end

   // A new item is taken whenever the result register is empty or is being
   // emptied in this same cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign opcode     = spd_op_type'(req_tuser);
   assign rx_byte    = req_tdata[7:0];
   assign read_index = req_tdata[12:8];

   // Indices at or above the buffer depth read as zero.
   assign rd_hit = (opcode == OP_READ_ENTRY) && (32'(read_index) < 32'(BUFFER_DEPTH));

   spd_frame_ctrl #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_frame_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .opcode         (opcode),
      .rx_byte        (rx_byte),
      .frame_mode     (mode_ff),
      .payload_length (len_ff),
      .status         (status),
      .wreq           (wreq),
      .wr_addr        (wr_addr)
   );

   // Writes and reads come from different items, and a read item is always
   // accepted after the write it depends on, so the read sees the stored byte
   // without forwarding.
   always_ff @(posedge clock) begin
      if (wreq.wr_en) begin
         store_mem[wr_addr] <= wreq.wr_data;
      end
      if (accept && rd_hit) begin
         rd_data_ff <= store_mem[AW'(read_index)];
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_status_ff <= status;
         rd_sel_ff     <= rd_hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_status_ff.frame_done;
   assign rsp_tdata  = {rsp_status_ff.overflow,
                        rsp_status_ff.payload_count,
                        rd_sel_ff ? rd_data_ff : 8'd0,
                        rsp_status_ff.ready_flag};

`include "serial_packet_deframer_top_macros.svh"

   `SPD_ASSERT(a_accept_gives_result, accept |=> rsp_tvalid, "accepted item left no result")
   `SPD_ASSERT(a_done_with_ready, rsp_tvalid && rsp_tlast |-> rsp_tdata[0], "frame end reported without ready")
   `SPD_ASSERT(a_read_selects_data, accept && rd_hit |=> rd_sel_ff, "buffer read not routed to result")

endmodule

[dv/spd_checker.sv]
// ----------------------------------------------------------------------------
// spd_checker
// Watches the item, result and register ports of the serial packet deframer.
// It keeps its own copy of the framing state and the payload buffer, predicts
// one result per accepted item and compares every accepted result with the
// oldest prediction still waiting, field by field.
// ----------------------------------------------------------------------------
module spd_checker #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [15:0]             req_tdata,   // [7:0] rx_byte, [12:8] read_index
   input  logic [1:0]              req_tuser,   // [1:0] opcode
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [15:0]             rsp_tdata,   // [0] ready_flag, [8:1] read_data,
                                                // [14:9] payload_count, [15] overflow
   input  logic                    rsp_tlast,   // frame_done
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   input  logic                    csr_pready,
   output int                      failure_count,
   output int                      pending_results,
   output logic [BUFFER_DEPTH-1:0] written_mask
);
   timeunit 1ns;
   timeprecision 1ps;
   import spd_pkg::*;

   typedef enum logic [1:0] {
      SCAN_HEADER  = 2'd0,
      SCAN_BODY    = 2'd1,
      SCAN_TRAILER = 2'd2
   } scan_phase_type;

   typedef struct packed {
      logic       ready_flag;
      logic       frame_done;
      logic [7:0] read_data;
      logic [5:0] payload_count;
      logic       overflow;
   } deframe_result_type;

   logic                    frame_mode;
   logic [5:0]              frame_len;
   scan_phase_type          scan_phase;
   logic [5:0]              stored_count;
   logic                    ready_set;
   logic                    chars_dropped;
   logic [7:0]              payload_copy [BUFFER_DEPTH];
   logic [BUFFER_DEPTH-1:0] written;
   deframe_result_type      expected_results [$];
   deframe_result_type      want;
   deframe_result_type      got;
   int                      fail_tally = 0;

   initial begin
      failure_count   = 0;
      pending_results = 0;
      written_mask    = '0;
   end

   task automatic keep_byte(input logic [5:0] pos, input logic [7:0] value);
      if (pos < BUFFER_DEPTH) begin
         payload_copy[pos] = value;
         written[pos]      = 1'b1;
      end
   endtask

   task automatic deframe_item(input logic [1:0] op, input logic [7:0] rx,
                               input logic [4:0] idx, output deframe_result_type res);
      int body_len;
      res      = '0;
      body_len = (frame_len == 0) ? 1 :
                 ((frame_len > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(frame_len));
      case (op)
         OP_RX_BYTE: begin
            case (scan_phase)
               SCAN_BODY: begin
                  if (frame_mode == MODE_BINARY) begin
                     keep_byte(stored_count, rx);
                     if (stored_count < BUFFER_DEPTH) stored_count = stored_count + 6'd1;
                     if (stored_count >= body_len) scan_phase = SCAN_TRAILER;
                  end else if (rx == CHR_CR) begin
                     scan_phase = SCAN_TRAILER;
                  end else if (int'(stored_count) + 1 < BUFFER_DEPTH) begin
                     keep_byte(stored_count, rx);
                     stored_count = stored_count + 6'd1;
                  end else begin
                     chars_dropped = 1'b1;
                  end
               end
               SCAN_TRAILER: begin
                  if (frame_mode == MODE_BINARY) begin
                     if (rx == TRL_BIN) begin
                        scan_phase     = SCAN_HEADER;
                        ready_set      = 1'b1;
                        res.frame_done = 1'b1;
                     end
                  end else if (rx == CHR_LF) begin
                     scan_phase = SCAN_HEADER;
                     keep_byte(stored_count, CHR_NUL);
                     ready_set      = 1'b1;
                     res.frame_done = 1'b1;
                  end
               end
               default: begin
                  // A text start is refused while a finished frame waits.
                  scan_phase = SCAN_HEADER;
                  if ((frame_mode == MODE_BINARY && rx == HDR_BIN) ||
                      (frame_mode == MODE_TEXT && rx == HDR_TXT && !ready_set)) begin
                     scan_phase    = SCAN_BODY;
                     stored_count  = '0;
                     chars_dropped = 1'b0;
                  end
               end
            endcase
            res.ready_flag = ready_set;
         end
         OP_READ_CLEAR: begin
            res.ready_flag = ready_set;
            ready_set      = 1'b0;
         end
         OP_READ_ENTRY: begin
            if (idx < BUFFER_DEPTH) res.read_data = payload_copy[idx];
            res.ready_flag = ready_set;
         end
         default: res.ready_flag = ready_set;
      endcase
      res.payload_count = stored_count;
      res.overflow      = chars_dropped;
   endtask

   task automatic check_field(input string field, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_mode    = MODE_BINARY;
         frame_len     = PAYLOAD_LENGTH_RESET;
         scan_phase    = SCAN_HEADER;
         stored_count  = '0;
         ready_set     = 1'b0;
         chars_dropped = 1'b0;
         written       = '0;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_PAYLOAD_LENGTH) frame_len = csr_pwdata[5:0];
            else frame_mode = csr_pwdata[0];
         end
         if (req_tvalid && req_tready) begin
            deframe_item(req_tuser, req_tdata[7:0], req_tdata[12:8], want);
            expected_results.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.ready_flag    = rsp_tdata[0];
            got.read_data     = rsp_tdata[8:1];
            got.payload_count = rsp_tdata[14:9];
            got.overflow      = rsp_tdata[15];
            got.frame_done    = rsp_tlast;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               fail_tally++;
            end else begin
               want = expected_results.pop_front();
               check_field("ready_flag", want.ready_flag, got.ready_flag);
               check_field("frame_done", want.frame_done, got.frame_done);
               check_field("read_data", want.read_data, got.read_data);
               check_field("payload_count", want.payload_count, got.payload_count);
               check_field("overflow", want.overflow, got.overflow);
            end
         end
      end
      failure_count   <= fail_tally;
      pending_results <= expected_results.size();
      written_mask    <= written;
   end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the serial packet deframer. A short directed run
// covers both framing modes, the flag clear, buffer reads and the reserved
// opcode; random phases then send mostly well-formed frames with random
// contents, mixed with noise, broken frames and reads, under a range of
// register settings and with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import spd_pkg::*;

   localparam int         BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH;
   localparam int         ITEM_TARGET  = 1100;
   // The last stretch of items runs with no idling on either side.
   localparam int         QUIET_TAIL   = 150;
   localparam int         CYCLE_LIMIT  = 200000;
   // The opcode field leaves one code unused; the block must treat it as a
   // status read that changes nothing.
   localparam logic [1:0] OP_RESERVED  = 2'd3;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // [7:0] rx_byte, [12:8] read_index, rest zero
   logic [1:0]  req_tuser   = '0;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // [0] ready_flag, [8:1] read_data,
                                    // [14:9] payload_count, [15] overflow
   logic        rsp_tlast;          // frame_done
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int                      failure_count;
   int                      pending_results;
   logic [BUFFER_DEPTH-1:0] written_mask;

   // Stimulus bookkeeping. The current settings shape the frames we build.
   logic       cur_mode       = MODE_BINARY;
   logic [5:0] cur_len        = PAYLOAD_LENGTH_RESET;
   bit         send_gaps      = 1'b1;
   bit         sink_stalls    = 1'b1;
   int         items_sent     = 0;
   int         op_count [4]   = '{0, 0, 0, 0};
   int         settings_used  = 0;
   int         frames_seen    = 0;
   int         cycle_count    = 0;

   // Register settings for the first random phases, extremes included. Text
   // mode ignores the length, but the register is still written each time.
   logic       plan_mode [8] = '{MODE_BINARY, MODE_TEXT, MODE_BINARY, MODE_TEXT,
                                 MODE_BINARY, MODE_BINARY, MODE_TEXT, MODE_BINARY};
   logic [5:0] plan_len  [8] = '{6'd32, 6'd4, 6'd1, 6'd63, 6'd0, 6'd63, 6'd0, 6'd9};

   serial_packet_deframer_top #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   spd_checker #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .failure_count   (failure_count),
      .pending_results (pending_results),
      .written_mask    (written_mask)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The run is cut short if it takes far longer than the slowest honest run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_results);
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready && rsp_tlast) frames_seen <= frames_seen + 1;
   end

   // Result side: the sink takes every result unless a stall burst is under
   // way. Stalls stop altogether in the final stretch of the run.
   initial begin
      forever begin
         @(posedge clock);
         if (sink_stalls && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Offers one item and returns at the edge that accepts it. tvalid stays
   // high afterwards, so back-to-back items need no dead cycle; a gap burst
   // drops it first.
   task automatic push_item(input logic [1:0] op, input logic [7:0] rx,
                            input logic [4:0] idx);
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, idx, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      op_count[op]++;
   endtask

   // The unused field of each item carries random bits all the same.
   task automatic send_byte(input logic [7:0] rx);
      push_item(OP_RX_BYTE, rx, 5'($urandom));
   endtask

   task automatic clear_ready();
      push_item(OP_READ_CLEAR, 8'($urandom), 5'($urandom));
   endtask

   task automatic read_entry(input logic [4:0] idx);
      push_item(OP_READ_ENTRY, 8'($urandom), idx);
   endtask

   // The buffer has no reset, so only entries the checker has seen written
   // are ever read. Its mask is registered and lags behind, which only makes it cautious.
   task automatic read_random_entry();
      logic [4:0] idx;
      bit         found;
      idx   = 5'($urandom_range(0, BUFFER_DEPTH - 1));
      found = 1'b0;
      for (int k = 0; k < BUFFER_DEPTH && !found; k++) begin
         if (written_mask[idx]) found = 1'b1;
         else idx = idx + 5'd1;
      end
      if (found) read_entry(idx);
      else clear_ready();
   endtask

   // Holds the sender off until every result has come back. The wait always
   // begins with a clock edge, as the checker's count is registered and lags behind.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   // One register write: setup cycle, then access cycle until pready. A
   // closing idle cycle keeps two writes from touching psel in one step.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Settings change only once the block has returned every result.
   task automatic configure(input logic mode, input logic [5:0] len);
      wait_drained();
      csr_write({REG_FRAME_MODE, 2'b00}, {31'd0, mode});
      csr_write({REG_PAYLOAD_LENGTH, 2'b00}, {26'd0, len});
      cur_mode = mode;
      cur_len  = len;
      settings_used++;
   endtask

   // Binary frame: header, payload of the effective length, a little junk
   // now and then, then the trailer. Roughly one frame in ten has a wrong
   // length, and about one in ten loses its trailer.
   task automatic send_binary_frame();
      int         body;
      logic [7:0] rx;
      body = (cur_len == 0) ? 1 :
             ((cur_len > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(cur_len));
      if ($urandom_range(0, 9) == 0) body = $urandom_range(0, body + 1);
      send_byte(HDR_BIN);
      repeat (body) send_byte(8'($urandom));
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) begin
         rx = 8'($urandom);
         if (rx == TRL_BIN) rx = CHR_NUL;
         send_byte(rx);
      end
      if ($urandom_range(0, 9) != 0) send_byte(TRL_BIN);
   endtask

   // Text frame: usually the pending flag is cleared first so that the start
   // character is taken. Now and then the line is long enough to overflow
   // the buffer, and now and then the line end is missing.
   task automatic send_text_frame();
      int         chars;
      logic [7:0] rx;
      if ($urandom_range(0, 3) != 0) clear_ready();
      chars = ($urandom_range(0, 5) == 0) ? $urandom_range(BUFFER_DEPTH - 4, BUFFER_DEPTH + 13)
                                          : $urandom_range(0, 12);
      send_byte(HDR_TXT);
      repeat (chars) begin
         rx = 8'($urandom);
         if (rx == CHR_CR) rx = HDR_TXT;
         send_byte(rx);
      end
      if ($urandom_range(0, 9) != 0) send_byte(CHR_CR);
      if ($urandom_range(0, 5) == 0) begin
         rx = 8'($urandom);
         if (rx == CHR_LF) rx = CHR_CR;
         send_byte(rx);
      end
      if ($urandom_range(0, 9) != 0) send_byte(CHR_LF);
   endtask

   // One random step: mostly a frame in the current mode, sometimes a frame
   // of the other kind (noise to the parser), sometimes stray items.
   task automatic random_step();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            if (cur_mode == MODE_BINARY) send_binary_frame();
            else send_text_frame();
            repeat ($urandom_range(0, 2)) read_random_entry();
         end
         6: begin
            if (cur_mode == MODE_BINARY) send_text_frame();
            else send_binary_frame();
         end
         7: send_byte(8'($urandom));
         8: begin
            if ($urandom_range(0, 1) == 0) clear_ready();
            else push_item(OP_RESERVED, 8'($urandom), 5'($urandom));
         end
         default: begin
            // Occasionally let everything drain before carrying on.
            if ($urandom_range(0, 3) == 0) wait_drained();
            read_random_entry();
         end
      endcase
   endtask

   initial begin
      int phase;
      int phase_end;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset settings: binary frames of four bytes.
      clear_ready();                              // nothing to clear yet
      push_item(OP_RESERVED, 8'hFF, 5'h1F);       // unused opcode
      send_byte(8'h12);                           // stray byte before a header
      send_byte(HDR_BIN);
      send_byte(8'h00);
      send_byte(8'hFF);                           // header value as payload
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'h7E);                           // not the trailer, ignored
      send_byte(TRL_BIN);
      read_entry(5'd0);
      read_entry(5'd3);
      send_byte(HDR_BIN);                         // new start while ready is set
      clear_ready();
      clear_ready();

      // Switch to text mode with the binary frame still open: the open body
      // carries on under the text rules and ends with CR and LF.
      configure(MODE_TEXT, 6'd1);
      send_byte(8'h68);
      send_byte(CHR_CR);
      send_byte(CHR_LF);
      send_byte(HDR_TXT);                         // refused while ready is set
      clear_ready();
      send_byte(HDR_TXT);
      send_byte(8'h80);
      send_byte(CHR_CR);
      send_byte(CHR_LF);
      read_entry(5'd1);                           // the stored terminator

      // Random phases, each under its own settings and idling pattern.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase < 8) configure(plan_mode[phase], plan_len[phase]);
         else configure(1'($urandom), 6'($urandom));
         send_gaps   = ($urandom_range(0, 2) != 0);
         sink_stalls = ($urandom_range(0, 2) != 0);
         phase_end   = items_sent + $urandom_range(90, 160);
         while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
               send_gaps   = 1'b0;
               sink_stalls = 1'b0;
            end
            random_step();
         end
         phase++;
      end

      wait_drained();
      repeat (4) @(posedge clock);

      $display("Ran %0d items: %0d bytes, %0d flag clears, %0d buffer reads, %0d unused opcodes.",
               items_sent, op_count[OP_RX_BYTE], op_count[OP_READ_CLEAR],
               op_count[OP_READ_ENTRY], op_count[OP_RESERVED]);
      $display("Saw %0d completed frames across %0d register settings.",
               frames_seen, settings_used);
      if (failure_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches found.", failure_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
